// File: rtl/mcht_pkg.sv
package mcht_pkg;

  localparam int unsigned AxisW   = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned SqW     = 32;
  localparam int unsigned SumW    = 34;
  localparam int unsigned ProdW   = 46;
  localparam int unsigned MulAW   = 34;
  localparam int unsigned MulBW   = 23;
  localparam int unsigned LvlW    = 7;
  localparam int unsigned NumAxes = 6;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [2:0] RegEnable   = 3'd0;
  localparam logic [2:0] RegAccelThr = 3'd1;
  localparam logic [2:0] RegGyroThr  = 3'd2;
  localparam logic [2:0] RegCooldown = 3'd3;
  localparam logic [2:0] RegPulse    = 3'd4;

  localparam logic              EnableRst   = 1'b1;
  localparam logic [ThrW-1:0]   AccelThrRst = 16'd4096;
  localparam logic [ThrW-1:0]   GyroThrRst  = 16'd4096;
  localparam logic [ThrW-1:0]   CooldownRst = 16'd1000;
  localparam logic [ThrW-1:0]   PulseRst    = 16'd500;

  // Square of the intensity scale of fifty.
  localparam logic [11:0]       LimScale    = 12'd2500;
  localparam logic [LvlW-1:0]   LevelMax    = 7'd100;
  localparam logic [LvlW-1:0]   LevelMin    = 7'd20;

  typedef struct packed {
    logic            enable;
    logic [ThrW-1:0] accel_thr;
    logic [ThrW-1:0] gyro_thr;
    logic [ThrW-1:0] cooldown;
    logic [ThrW-1:0] pulse;
  } cfg_t;

endpackage

// File: rtl/mcht_if.sv
interface mcht_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [mcht_pkg::AxisW-1:0]   accel_x;
  logic signed [mcht_pkg::AxisW-1:0]   accel_y;
  logic signed [mcht_pkg::AxisW-1:0]   accel_z;
  logic signed [mcht_pkg::AxisW-1:0]   gyro_x;
  logic signed [mcht_pkg::AxisW-1:0]   gyro_y;
  logic signed [mcht_pkg::AxisW-1:0]   gyro_z;
  logic        [mcht_pkg::TimeW-1:0]   time_ms;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms,
                  output ready);
endinterface

interface mcht_result_if;
  logic                           valid;
  logic                           ready;
  logic                           vibrate;
  logic [mcht_pkg::LvlW-1:0]      intensity;
  logic [mcht_pkg::ThrW-1:0]      duration_ms;
  logic                           accel_fired;
  logic                           gyro_fired;

  modport source (output valid, vibrate, intensity, duration_ms, accel_fired, gyro_fired,
                  input ready);
  modport sink   (input valid, vibrate, intensity, duration_ms, accel_fired, gyro_fired,
                  output ready);
endinterface

// File: rtl/mcht_regs.sv
module mcht_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcht_pkg::AddrW-1:0]    paddr,
  input  logic [mcht_pkg::DataW-1:0]    pwdata,
  output logic [mcht_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output mcht_pkg::cfg_t                cfg_o
);

  mcht_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        mcht_pkg::RegEnable:   cfg_d.enable    = pwdata[0];
        mcht_pkg::RegAccelThr: cfg_d.accel_thr = pwdata[15:0];
        mcht_pkg::RegGyroThr:  cfg_d.gyro_thr  = pwdata[15:0];
        mcht_pkg::RegCooldown: cfg_d.cooldown  = pwdata[15:0];
        mcht_pkg::RegPulse:    cfg_d.pulse     = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mcht_pkg::RegEnable:   prdata = {31'b0, cfg_q.enable};
      mcht_pkg::RegAccelThr: prdata = {16'b0, cfg_q.accel_thr};
      mcht_pkg::RegGyroThr:  prdata = {16'b0, cfg_q.gyro_thr};
      mcht_pkg::RegCooldown: prdata = {16'b0, cfg_q.cooldown};
      mcht_pkg::RegPulse:    prdata = {16'b0, cfg_q.pulse};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= mcht_pkg::EnableRst;
      cfg_q.accel_thr <= mcht_pkg::AccelThrRst;
      cfg_q.gyro_thr  <= mcht_pkg::GyroThrRst;
      cfg_q.cooldown  <= mcht_pkg::CooldownRst;
      cfg_q.pulse     <= mcht_pkg::PulseRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/motion_change_haptic_trigger.sv
// A beat that arrives while disabled, priming or in cooldown goes from the check straight
// to the result register; otherwise both sensors are checked against their thresholds.
// A new beat is accepted only in idle, once the previous result is registered. The single
// shared multiplier forms the squares and runs a 7-step search for each firing sensor.
// Reset restores the register defaults, drops the reference sample, zeroes the last
// trigger time and empties the result register.
module motion_change_haptic_trigger (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mcht_sample_if.sink                   sample_i,
  mcht_result_if.source                 result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcht_pkg::AddrW-1:0]    paddr,
  input  logic [mcht_pkg::DataW-1:0]    pwdata,
  output logic [mcht_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StCheck = 4'd1;
  localparam logic [3:0] StSq    = 4'd2;
  localparam logic [3:0] StAcc   = 4'd3;
  localparam logic [3:0] StTt    = 4'd4;
  localparam logic [3:0] StCmp   = 4'd5;
  localparam logic [3:0] StLim   = 4'd6;
  localparam logic [3:0] StLatch = 4'd7;
  localparam logic [3:0] StKt    = 4'd8;
  localparam logic [3:0] StKsq   = 4'd9;
  localparam logic [3:0] StKcmp  = 4'd10;
  localparam logic [3:0] StLvl   = 4'd11;
  localparam logic [3:0] StFin   = 4'd12;
  localparam logic [3:0] StOut   = 4'd13;

  localparam logic [2:0] LastAxis  = 3'(mcht_pkg::NumAxes - 1);
  localparam logic [2:0] FirstAxisG = 3'(mcht_pkg::NumAxes / 2);

  mcht_pkg::cfg_t cfg;

  mcht_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [3:0]                    state_q, state_d;
  logic [mcht_pkg::AxisW-1:0]    smp_q [mcht_pkg::NumAxes];
  logic [mcht_pkg::TimeW-1:0]    time_q;
  logic [mcht_pkg::AxisW-1:0]    prev_q [mcht_pkg::NumAxes];
  logic [mcht_pkg::AxisW-1:0]    prev_d [mcht_pkg::NumAxes];
  logic                          primed_q, primed_d;
  logic [mcht_pkg::TimeW-1:0]    last_q, last_d;
  logic [mcht_pkg::SumW-1:0]     sum_q [2];
  logic [mcht_pkg::SumW-1:0]     sum_d [2];
  logic [mcht_pkg::ProdW-1:0]    prod_q, prod_d;
  logic [mcht_pkg::ProdW-1:0]    lim_q, lim_d;
  logic [mcht_pkg::LvlW-1:0]     k_q, k_d;
  logic [2:0]                    bit_q, bit_d;
  logic [2:0]                    idx_q, idx_d;
  logic                          sens_q, sens_d;
  logic [1:0]                    fired_q, fired_d;
  logic [mcht_pkg::LvlW-1:0]     level_q, level_d;

  logic                          out_valid_q, out_valid_d;
  logic                          out_vib_q, out_vib_d;
  logic [mcht_pkg::LvlW-1:0]     out_int_q, out_int_d;
  logic [mcht_pkg::ThrW-1:0]     out_dur_q, out_dur_d;
  logic                          out_af_q, out_af_d;
  logic                          out_gf_q, out_gf_d;

  logic                          accept;
  logic                          out_take;
  logic [mcht_pkg::AxisW:0]      diff;
  logic [mcht_pkg::AxisW:0]      diff_abs;
  logic [mcht_pkg::AxisW-1:0]    mag;
  logic [mcht_pkg::ThrW-1:0]     thr;
  logic [mcht_pkg::LvlW-1:0]     trial;
  logic [mcht_pkg::LvlW-1:0]     k_clip;
  logic [mcht_pkg::TimeW-1:0]    elapsed;
  logic [mcht_pkg::MulAW-1:0]    mul_a;
  logic [mcht_pkg::MulBW-1:0]    mul_b;
  logic [mcht_pkg::MulAW+mcht_pkg::MulBW-1:0] mul_p;
  logic                          sum_sel;
  logic                          vib;

  assign accept         = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == StIdle);
  assign out_take       = !out_valid_q || result_o.ready;

  assign diff     = {smp_q[idx_q][mcht_pkg::AxisW-1], smp_q[idx_q]}
                  - {prev_q[idx_q][mcht_pkg::AxisW-1], prev_q[idx_q]};
  assign diff_abs = diff[mcht_pkg::AxisW] ? (~diff + 17'd1) : diff;
  assign mag      = diff_abs[mcht_pkg::AxisW-1:0];
  assign thr      = sens_q ? cfg.gyro_thr : cfg.accel_thr;
  assign trial    = k_q | (7'd1 << bit_q);
  assign k_clip   = (k_q > mcht_pkg::LevelMax) ? mcht_pkg::LevelMax : k_q;
  assign elapsed  = time_q - last_q;
  assign sum_sel  = (idx_q >= FirstAxisG);
  assign vib      = fired_q[0] || fired_q[1];

  always_comb begin
    case (state_q)
      StSq: begin
        mul_a = {18'b0, mag};
        mul_b = {7'b0, mag};
      end
      StTt: begin
        mul_a = {18'b0, thr};
        mul_b = {7'b0, thr};
      end
      StLim: begin
        mul_a = sum_q[sens_q];
        mul_b = {11'b0, mcht_pkg::LimScale};
      end
      StKt: begin
        mul_a = {27'b0, trial};
        mul_b = {7'b0, thr};
      end
      StKsq: begin
        mul_a = {11'b0, prod_q[22:0]};
        mul_b = prod_q[22:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    primed_d    = primed_q;
    last_d      = last_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    lim_d       = lim_q;
    k_d         = k_q;
    bit_d       = bit_q;
    idx_d       = idx_q;
    sens_d      = sens_q;
    fired_d     = fired_q;
    level_d     = level_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_vib_d   = out_vib_q;
    out_int_d   = out_int_q;
    out_dur_d   = out_dur_q;
    out_af_d    = out_af_q;
    out_gf_d    = out_gf_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        fired_d  = 2'b00;
        level_d  = '0;
        sum_d[0] = '0;
        sum_d[1] = '0;
        idx_d    = '0;
        sens_d   = 1'b0;
        if (!cfg.enable) begin
          state_d = StOut;
        end else if (!primed_q) begin
          prev_d   = smp_q;
          primed_d = 1'b1;
          state_d  = StOut;
        end else if (elapsed < {16'b0, cfg.cooldown}) begin
          state_d = StOut;
        end else begin
          state_d = StSq;
        end
      end
      StSq: begin
        prod_d  = mul_p[mcht_pkg::ProdW-1:0];
        state_d = StAcc;
      end
      StAcc: begin
        sum_d[sum_sel] = sum_q[sum_sel] + {2'b0, prod_q[mcht_pkg::SqW-1:0]};
        idx_d          = idx_q + 3'd1;
        state_d        = (idx_q == LastAxis) ? StTt : StSq;
      end
      StTt: begin
        prod_d  = mul_p[mcht_pkg::ProdW-1:0];
        state_d = StCmp;
      end
      StCmp: begin
        if (sum_q[sens_q] > {2'b0, prod_q[mcht_pkg::SqW-1:0]}) begin
          fired_d[sens_q] = 1'b1;
          k_d             = '0;
          bit_d           = 3'(mcht_pkg::LvlW - 1);
          state_d         = StLim;
        end else if (!sens_q) begin
          sens_d  = 1'b1;
          state_d = StTt;
        end else begin
          state_d = StFin;
        end
      end
      StLim: begin
        prod_d  = mul_p[mcht_pkg::ProdW-1:0];
        state_d = StLatch;
      end
      StLatch: begin
        lim_d   = prod_q;
        state_d = StKt;
      end
      StKt: begin
        prod_d  = mul_p[mcht_pkg::ProdW-1:0];
        state_d = StKsq;
      end
      StKsq: begin
        prod_d  = mul_p[mcht_pkg::ProdW-1:0];
        state_d = StKcmp;
      end
      StKcmp: begin
        if (prod_q <= lim_q) begin
          k_d = trial;
        end
        if (bit_q == 3'd0) begin
          state_d = StLvl;
        end else begin
          bit_d   = bit_q - 3'd1;
          state_d = StKt;
        end
      end
      StLvl: begin
        if (k_clip > level_q) begin
          level_d = k_clip;
        end
        if (!sens_q) begin
          sens_d  = 1'b1;
          state_d = StTt;
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        prev_d = smp_q;
        if (vib) begin
          last_d = time_q;
        end
        state_d = StOut;
      end
      StOut: begin
        if (out_take) begin
          out_valid_d = 1'b1;
          out_vib_d   = vib;
          out_int_d   = !vib ? '0
                      : (level_q < mcht_pkg::LevelMin) ? mcht_pkg::LevelMin : level_q;
          out_dur_d   = vib ? cfg.pulse : '0;
          out_af_d    = fired_q[0];
          out_gf_d    = fired_q[1];
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_q      <= '{default: '0};
      primed_q    <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      primed_q    <= primed_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q[0] <= sample_i.accel_x;
      smp_q[1] <= sample_i.accel_y;
      smp_q[2] <= sample_i.accel_z;
      smp_q[3] <= sample_i.gyro_x;
      smp_q[4] <= sample_i.gyro_y;
      smp_q[5] <= sample_i.gyro_z;
      time_q   <= sample_i.time_ms;
    end
    sum_q     <= sum_d;
    prod_q    <= prod_d;
    lim_q     <= lim_d;
    k_q       <= k_d;
    bit_q     <= bit_d;
    idx_q     <= idx_d;
    sens_q    <= sens_d;
    fired_q   <= fired_d;
    level_q   <= level_d;
    out_vib_q <= out_vib_d;
    out_int_q <= out_int_d;
    out_dur_q <= out_dur_d;
    out_af_q  <= out_af_d;
    out_gf_q  <= out_gf_d;
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.vibrate     = out_vib_q;
  assign result_o.intensity   = out_int_q;
  assign result_o.duration_ms = out_dur_q;
  assign result_o.accel_fired = out_af_q;
  assign result_o.gyro_fired  = out_gf_q;

endmodule
